FILE: rtl/pctd_pkg.sv
// Shared types, constants and hex digit mapping for the percent decoder.
package pctd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_RESULTS = 3;

   localparam logic [7:0] PCT_CHAR = 8'h25;

   // held_count codes
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_PCT  = 2'd1;
   localparam logic [1:0] HELD_PAIR = 2'd2;

   typedef logic [1:0] res_cnt_type;

   // One accepted input's worth of results.
   typedef struct packed {
      res_cnt_type                      num;
      logic [MAX_RESULTS-1:0][7:0]      data;
      logic                             last;
   } entry_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
      end
      return t[3:0];
   endfunction

endpackage

FILE: rtl/pctd_front.sv
// Front end: accepts input beats, tracks held escape bytes, builds result entries.
module pctd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   input  logic                 req_in_last,
   input  logic                 q_full,
   output logic                 q_push,
   output pctd_pkg::entry_type  q_entry
);

   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  held_dig_ff, held_dig_in;
   logic        accept;
   logic [1:0]  cnt;
   logic [7:0]  dig;
   logic [7:0]  v;
   logic [7:0]  sb;
   logic        pair;
   logic        rescan;
   logic        scan_en;
   pctd_pkg::res_cnt_type                      n;
   logic [pctd_pkg::MAX_RESULTS-1:0][7:0]      res;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      cnt     = held_cnt_ff;
      dig     = held_dig_ff;
      n       = '0;
      res     = '0;
      sb      = 8'h00;
      scan_en = 1'b0;
      if (cnt == 2'd3) begin
         cnt = pctd_pkg::HELD_NONE;
      end
      pair   = (cnt == pctd_pkg::HELD_PAIR);
      v      = {pctd_pkg::hex_value(held_dig_ff), pctd_pkg::hex_value(req_in_byte)};
      rescan = pair && (v == 8'h00);
      if (pair) begin
         cnt = pctd_pkg::HELD_NONE;
         dig = 8'h00;
         res[n] = rescan ? pctd_pkg::PCT_CHAR : v;
         n = n + 2'd1;
      end
      // zero pair: held byte then new byte are scanned again
      for (int k = 0; k < 2; k++) begin
         if (k == 0) begin
            scan_en = rescan;
            sb      = held_dig_ff;
         end else begin
            scan_en = rescan || !pair;
            sb      = req_in_byte;
         end
         if (scan_en) begin
            if (cnt == pctd_pkg::HELD_PCT) begin
               dig = sb;
               cnt = pctd_pkg::HELD_PAIR;
            end else if (sb == pctd_pkg::PCT_CHAR) begin
               cnt = pctd_pkg::HELD_PCT;
            end else if (n != 2'd3) begin
               res[n] = sb;
               n = n + 2'd1;
            end
         end
      end
      if (req_in_last) begin
         if (cnt != pctd_pkg::HELD_NONE && n != 2'd3) begin
            res[n] = pctd_pkg::PCT_CHAR;
            n = n + 2'd1;
         end
         if (cnt == pctd_pkg::HELD_PAIR && n != 2'd3) begin
            res[n] = dig;
            n = n + 2'd1;
         end
         cnt = pctd_pkg::HELD_NONE;
         dig = 8'h00;
      end
   end

   assign held_cnt_in = accept ? cnt : held_cnt_ff;
   assign held_dig_in = accept ? dig : held_dig_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= pctd_pkg::HELD_NONE;
         held_dig_ff <= 8'h00;
      end else begin
         held_cnt_ff <= held_cnt_in;
         held_dig_ff <= held_dig_in;
      end
   end

   assign q_push       = accept && (n != 2'd0);
   assign q_entry.num  = n;
   assign q_entry.data = res;
   assign q_entry.last = req_in_last;

   a_held_code: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff != 2'd3)
      else $error("held count reached unused code");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_last) |-> q_push)
      else $error("last beat produced no entry");

endmodule

FILE: rtl/pctd_queue.sv
// Short entry queue between front end and output serializer.
module pctd_queue #(
   parameter int DEPTH = pctd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pctd_pkg::entry_type  push_entry,
   input  logic                 pop,
   output pctd_pkg::entry_type  pop_entry,
   output logic                 full,
   output logic                 empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pctd_pkg::entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       do_push;
   logic                       do_pop;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count overflow");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("queue count did not follow push");

endmodule

FILE: rtl/pctd_back.sv
// Back end: serializes queued entries into single output beats.
module pctd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  pctd_pkg::entry_type  q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last
);

   pctd_pkg::entry_type        ent_ff, ent_in;
   logic                       ent_vld_ff, ent_vld_in;
   pctd_pkg::res_cnt_type      idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       out_free;
   logic                       send;
   logic                       last_idx;
   logic                       ent_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign send     = out_free && ent_vld_ff;
   assign last_idx = (idx_ff == ent_ff.num - 2'd1);
   assign ent_done = send && last_idx;
   assign q_pop    = !q_empty && (!ent_vld_ff || ent_done);

   always_comb begin
      ent_in     = ent_ff;
      ent_vld_in = ent_vld_ff;
      idx_in     = idx_ff;
      if (q_pop) begin
         ent_in     = q_entry;
         ent_vld_in = 1'b1;
         idx_in     = '0;
      end else if (ent_done) begin
         ent_vld_in = 1'b0;
      end else if (send) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      if (out_free) begin
         rsp_valid_in = ent_vld_ff;
      end
      if (send) begin
         byte_in = ent_ff.data[idx_ff];
         last_in = ent_ff.last && last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         ent_vld_ff   <= ent_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

   a_ent_nonempty: assert property (@(posedge clock) disable iff (reset)
      ent_vld_ff |-> (ent_ff.num != 2'd0 && idx_ff < ent_ff.num))
      else $error("held entry has no byte at current index");

endmodule

FILE: rtl/percent_decoder.sv
// Top level of the lenient percent decoder: front end, entry queue, serializer.
//
//   channel  | valid      | stall      | beat fields
//   ---------+------------+------------+------------------------------
//   input    | req_valid  | req_stall  | req_in_byte, req_in_last
//   output   | rsp_valid  | rsp_stall  | rsp_out_byte, rsp_out_last
//
// One input beat per cycle while req_stall is low; each yields zero to three output beats in order.
// Output rate is one beat per cycle while rsp_stall is low, set by the serializer's single output register.
// A result passes through the queue, the serializer's entry register and its output register.
// req_stall rises only when the QUEUE_DEPTH-entry queue is full.
// Synchronous active-high reset clears held bytes, queue and output valid.
module percent_decoder #(
   parameter int QUEUE_DEPTH = pctd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last
);

   logic                 q_push;
   logic                 q_pop;
   logic                 q_full;
   logic                 q_empty;
   pctd_pkg::entry_type  push_entry;
   pctd_pkg::entry_type  pop_entry;

   pctd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   pctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   pctd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_entry      (pop_entry),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the percent decoder: random and directed strings, beat checks.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 60000;
   localparam int RANDOM_ITEMS = 245;

   typedef struct packed {
      logic [7:0] code;
      logic       fin;
   } enc_beat_type;

   typedef struct packed {
      logic [7:0] text;
      logic       fin;
   } dec_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   enc_beat_type  pending_q[$];
   dec_beat_type  expected_q[$];

   // decoder state
   logic [1:0] held_cnt = pctd_pkg::HELD_NONE;
   logic [7:0] held_byte = 8'h00;
   logic [7:0] out_buf[pctd_pkg::MAX_RESULTS];
   int         out_n;

   int         cycle_count = 0;
   int         accepted = 0;
   int         strings = 0;
   int         checked = 0;
   int         errors = 0;
   logic       calm;

   assign calm = accepted >= 110 && accepted < 170;

   percent_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [3:0] digit_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return c[3:0];
      end
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         return c[3:0] + 4'd9;
      end
      return 4'd0;
   endfunction

   task automatic put(input logic [7:0] b);
      if (out_n < pctd_pkg::MAX_RESULTS) begin
         out_buf[out_n] = b;
         out_n++;
      end
   endtask

   task automatic scan_plain(input logic [7:0] b);
      if (held_cnt == pctd_pkg::HELD_PCT) begin
         held_byte = b;
         held_cnt = pctd_pkg::HELD_PAIR;
      end else if (b == pctd_pkg::PCT_CHAR) begin
         held_cnt = pctd_pkg::HELD_PCT;
      end else begin
         put(b);
      end
   endtask

   task automatic decode_beat(input logic [7:0] b, input logic fin);
      logic [7:0] first;
      logic [7:0] val;
      out_n = 0;
      if (held_cnt > pctd_pkg::HELD_PAIR) begin
         held_cnt = pctd_pkg::HELD_NONE;
      end
      if (held_cnt == pctd_pkg::HELD_PAIR) begin
         first = held_byte;
         val = {digit_of(first), digit_of(b)};
         held_cnt = pctd_pkg::HELD_NONE;
         held_byte = 8'h00;
         if (val != 8'h00) begin
            put(val);
         end else begin
            // zero pair: literal '%', both bytes rescanned
            put(pctd_pkg::PCT_CHAR);
            scan_plain(first);
            scan_plain(b);
         end
      end else begin
         scan_plain(b);
      end
      if (fin) begin
         if (held_cnt != pctd_pkg::HELD_NONE) begin
            put(pctd_pkg::PCT_CHAR);
         end
         if (held_cnt == pctd_pkg::HELD_PAIR) begin
            put(held_byte);
         end
         held_cnt = pctd_pkg::HELD_NONE;
         held_byte = 8'h00;
      end
      for (int k = 0; k < out_n; k++) begin
         expected_q.insert(expected_q.size(),
                           dec_beat_type'{text: out_buf[k], fin: fin && k == out_n - 1});
      end
   endtask

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
      errors++;
   endtask

   task automatic add_beat(input logic [7:0] b, input logic fin);
      pending_q.insert(pending_q.size(), enc_beat_type'{code: b, fin: fin});
      if (fin) begin
         strings++;
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_beat(s[i], i == s.len() - 1);
      end
   endtask

   // input side
   always @(posedge clock) begin : drive
      enc_beat_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_beat(req_in_byte, req_in_last);
            accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
               nxt = pending_q.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= nxt.code;
               req_in_last <= nxt.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // output side
   always @(posedge clock) begin : watch
      dec_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_q.size() == 0) begin
               report("unexpected beat, byte", rsp_out_byte, 8'h00);
            end else begin
               want = expected_q.pop_front();
               if (rsp_out_byte != want.text) begin
                  report("out_byte", rsp_out_byte, want.text);
               end
               if (rsp_out_last != want.fin) begin
                  report("out_last", {7'd0, rsp_out_last}, {7'd0, want.fin});
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 21);
      end
   end

   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      string   hexes;
      string   edges;
      int      len;
      int      pick;
      logic    noise;
      logic [7:0] b;
      hexes = "0123456789ABCDEFabcdef";
      edges = "/:@G`g";

      add_text("%41");
      add_text("%Fa");
      add_text("%zz");
      add_text("%0%");
      add_text("%4");
      add_text("%");
      add_text("a%");
      add_text("%0%41");
      add_beat(8'h00, 1'b1);
      add_beat(8'hFF, 1'b1);

      while (pending_q.size() < RANDOM_ITEMS + 24) begin
         len = $urandom_range(1, 8);
         noise = $urandom_range(9) >= 8;
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(9);
            if (noise || pick == 7 || pick == 8) begin
               b = 8'($urandom_range(255));
            end else if (pick <= 2) begin
               b = pctd_pkg::PCT_CHAR;
            end else if (pick <= 6) begin
               b = hexes[$urandom_range(hexes.len() - 1)];
            end else begin
               b = edges[$urandom_range(edges.len() - 1)];
            end
            add_beat(b, i == len - 1);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_q.size() > 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("%0d input beats in %0d strings sent, %0d output beats checked",
               accepted, strings, checked);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches found", errors);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
